// ----- rtl/sbc_pkg.sv -----
package sbc_pkg;

	localparam int CoordW      = 24;
	localparam int EnergyW     = 32;
	localparam int NumAxes     = 3;
	localparam int NumFaces    = 6;
	localparam int CfgIdxW     = 3;
	localparam int FracOutW    = 17;
	localparam int FracOutBits = 16;
	localparam int MuFracDef   = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_X = 3'd0,
		REG_MAX_X = 3'd1,
		REG_MIN_Y = 3'd2,
		REG_MAX_Y = 3'd3,
		REG_MIN_Z = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic active;
		logic outward;
		logic negative;
		logic positive;
	} face_flags_t;

	typedef struct packed {
		logic [EnergyW-1:0]           energy;
		logic                         zero_len;
		face_flags_t [NumFaces-1:0]   face;
	} side_t;

endpackage

// ----- rtl/sbc_prep.sv -----
module sbc_prep
	import sbc_pkg::*;
(
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [NumAxes-1:0][CoordW-1:0]      start_pt,
	input  logic [NumAxes-1:0][CoordW-1:0]      end_pt,
	input  logic [EnergyW-1:0]                  energy,
	input  logic [NumFaces-1:0][CoordW-1:0]     box,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [NumFaces-1:0][CoordW-1:0]     anum,
	output logic [NumFaces-1:0][CoordW-1:0]     ad,
	output side_t                               side
);

	logic                    v_s1, v_s2, rdy_s1, rdy_s2;
	logic signed [CoordW:0]  d_s1 [NumAxes];
	logic signed [CoordW:0]  num_s1 [NumFaces];
	logic [EnergyW-1:0]      energy_s1;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			for (int a = 0; a < NumAxes; a++) begin
				d_s1[a] <= $signed({end_pt[a][CoordW-1], end_pt[a]})
					- $signed({start_pt[a][CoordW-1], start_pt[a]});
			end
			for (int f = 0; f < NumFaces; f++) begin
				num_s1[f] <= $signed({box[f][CoordW-1], box[f]})
					- $signed({start_pt[f/2][CoordW-1], start_pt[f/2]});
			end
			energy_s1 <= energy;
		end
	end

	logic [NumFaces-1:0][CoordW-1:0] anum_n, ad_n;
	side_t                           side_n;

	always_comb begin
		logic signed [CoordW:0] dv, nv;
		logic [CoordW:0]        an, dn;
		side_n.energy   = energy_s1;
		side_n.zero_len = (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);
		for (int f = 0; f < NumFaces; f++) begin
			dv = d_s1[f/2];
			nv = num_s1[f];
			an = nv[CoordW] ? -nv : nv;
			dn = dv[CoordW] ? -dv : dv;
			anum_n[f] = an[CoordW-1:0];
			ad_n[f]   = dn[CoordW-1:0];
			side_n.face[f].active   = (dv != '0);
			// odd faces are max faces: outward is +axis
			side_n.face[f].outward  = (f % 2 == 1) ? (!dv[CoordW] && dv != '0) : dv[CoordW];
			side_n.face[f].negative = (nv != '0) && (nv[CoordW] != dv[CoordW]);
			side_n.face[f].positive = (nv != '0) && (nv[CoordW] == dv[CoordW]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			anum <= anum_n;
			ad   <= ad_n;
			side <= side_n;
		end
	end

	assign out_valid = v_s2;

endmodule

// ----- rtl/sbc_divider.sv -----
module sbc_divider
	import sbc_pkg::*;
#(
	parameter int MuFracBits = MuFracDef
)(
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [NumFaces-1:0][CoordW-1:0]     anum,
	input  logic [NumFaces-1:0][CoordW-1:0]     ad,
	input  side_t                               side_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [NumFaces-1:0][MuFracBits-1:0] quot,
	output logic [NumFaces-1:0]                 sat,
	output side_t                               side_out
);

	localparam int Last = MuFracBits - 1;

	logic [MuFracBits-1:0]                   v_s, rdy_s;
	logic [NumFaces-1:0][CoordW-1:0]         rem_s  [MuFracBits];
	logic [NumFaces-1:0][CoordW-1:0]         ad_s   [MuFracBits];
	logic [NumFaces-1:0][MuFracBits-1:0]     q_s    [MuFracBits];
	logic [NumFaces-1:0]                     sat_s  [MuFracBits];
	side_t                                   side_s [MuFracBits];

	assign in_ready = rdy_s[0];

	for (genvar k = 0; k < MuFracBits; k++) begin : g_stage
		logic                                src_v;
		logic [NumFaces-1:0][CoordW-1:0]     src_rem, src_ad;
		logic [NumFaces-1:0][MuFracBits-1:0] src_q;
		logic [NumFaces-1:0]                 src_sat;
		side_t                               src_side;
		logic [NumFaces-1:0][CoordW-1:0]     rem_n;
		logic [NumFaces-1:0][MuFracBits-1:0] q_n;

		if (k == 0) begin : g_first
			assign src_v    = in_valid;
			assign src_rem  = anum;
			assign src_ad   = ad;
			assign src_q    = '0;
			assign src_side = side_in;
			for (genvar f = 0; f < NumFaces; f++) begin : g_sat
				// quotient of one or more saturates
				assign src_sat[f] = (anum[f] >= ad[f]);
			end
		end else begin : g_next
			assign src_v    = v_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_ad   = ad_s[k-1];
			assign src_q    = q_s[k-1];
			assign src_sat  = sat_s[k-1];
			assign src_side = side_s[k-1];
		end

		if (k == Last) begin : g_rdy_last
			assign rdy_s[k] = !v_s[k] || out_ready;
		end else begin : g_rdy
			assign rdy_s[k] = !v_s[k] || rdy_s[k+1];
		end

		always_comb begin
			logic [CoordW:0] trial;
			logic            ge;
			for (int f = 0; f < NumFaces; f++) begin
				trial    = {src_rem[f], 1'b0};
				ge       = (trial >= {1'b0, src_ad[f]});
				rem_n[f] = ge ? CoordW'(trial - {1'b0, src_ad[f]}) : trial[CoordW-1:0];
				q_n[f]   = {src_q[f][MuFracBits-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy_s[k]) begin
				v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[k] && src_v) begin
				rem_s[k]  <= rem_n;
				ad_s[k]   <= src_ad;
				q_s[k]    <= q_n;
				sat_s[k]  <= src_sat;
				side_s[k] <= src_side;
			end
		end
	end

	assign out_valid = v_s[Last];
	assign quot      = q_s[Last];
	assign sat       = sat_s[Last];
	assign side_out  = side_s[Last];

endmodule

// ----- rtl/sbc_resolve.sv -----
module sbc_resolve
	import sbc_pkg::*;
#(
	parameter int MuFracBits = MuFracDef
)(
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [NumFaces-1:0][MuFracBits-1:0] quot,
	input  logic [NumFaces-1:0]                 sat,
	input  side_t                               side,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [FracOutW-1:0]                 contained_fraction,
	output logic [EnergyW-1:0]                  escaped_energy,
	output logic [EnergyW-1:0]                  counted_energy,
	output logic                                fully_escaped,
	output logic                                zero_length
);

	localparam int MuW   = MuFracBits + 1;
	localparam int ProdW = EnergyW + MuW + 1;
	localparam logic [MuW-1:0] One = MuW'(1) << MuFracBits;
	localparam logic [ProdW-1:0] Half = ProdW'(1) << (MuFracBits - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: narrow the interval over all faces
	logic [MuW-1:0] lo_n, hi_n;
	logic           force_n;

	always_comb begin
		logic [MuW-1:0] mu;
		lo_n    = '0;
		hi_n    = One;
		force_n = 1'b0;
		for (int f = 0; f < NumFaces; f++) begin
			mu = sat[f] ? One : {1'b0, quot[f]};
			if (side.face[f].active) begin
				if (side.face[f].outward) begin
					if (side.face[f].negative) force_n = 1'b1;
					else if (mu < hi_n) hi_n = mu;
				end else if (side.face[f].positive && mu > lo_n) begin
					lo_n = mu;
				end
			end
		end
	end

	logic [MuW-1:0]     lo_s1, hi_s1;
	logic               force_s1, zero_s1;
	logic [EnergyW-1:0] energy_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			lo_s1     <= lo_n;
			hi_s1     <= hi_n;
			force_s1  <= force_n;
			zero_s1   <= side.zero_len;
			energy_s1 <= side.energy;
		end
	end

	// stage 2: fraction and its complement
	logic [MuW-1:0]     frac_s2, rest_s2;
	logic               force_s2, zero_s2;
	logic [EnergyW-1:0] energy_s2;

	always_ff @(posedge clk) begin
		logic [MuW-1:0] fr;
		if (rdy_s2 && v_s1) begin
			fr        = (!force_s1 && hi_s1 > lo_s1) ? (hi_s1 - lo_s1) : '0;
			frac_s2   <= fr;
			rest_s2   <= One - fr;
			force_s2  <= force_s1;
			zero_s2   <= zero_s1;
			energy_s2 <= energy_s1;
		end
	end

	// stage 3: scale energy by the escaped part
	logic [ProdW-1:0]   prod_s3;
	logic [MuW-1:0]     frac_s3;
	logic               force_s3, zero_s3;
	logic [EnergyW-1:0] energy_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			prod_s3   <= ProdW'(energy_s2) * ProdW'(rest_s2);
			frac_s3   <= frac_s2;
			force_s3  <= force_s2;
			zero_s3   <= zero_s2;
			energy_s3 <= energy_s2;
		end
	end

	// stage 4: round and drive the result register
	always_ff @(posedge clk) begin
		logic [ProdW-1:0]        rounded;
		logic [MuW+FracOutBits-1:0] fw;
		if (rdy_s4 && v_s3) begin
			rounded = (prod_s3 + Half) >> MuFracBits;
			fw      = {{FracOutBits{1'b0}}, frac_s3} << FracOutBits;
			fw      = fw >> MuFracBits;
			if (zero_s3) begin
				contained_fraction <= '0;
				escaped_energy     <= '0;
				counted_energy     <= '0;
				fully_escaped      <= 1'b0;
				zero_length        <= 1'b1;
			end else begin
				contained_fraction <= fw[FracOutW-1:0];
				escaped_energy     <= rounded[EnergyW-1:0];
				counted_energy     <= energy_s3;
				fully_escaped      <= force_s3;
				zero_length        <= 1'b0;
			end
		end
	end

	assign out_valid = v_s4;

endmodule

// ----- rtl/segment_box_containment_unit.sv -----
// Channel   | Handshake             | Payload
// s_axis    | s_axis_tvalid/tready  | tdata: start_x,y,z, end_x,y,z, kinetic_energy
// m_axis    | m_axis_tvalid/tready  | tdata: fraction, escaped, counted; tuser: flags
// cfg       | cfg_valid/cfg_ready   | cfg_index, cfg_data (box bounds)
//
// One segment per cycle sustained while m_axis is not stalled; the divider has
// one-bit-per-stage lanes, one lane per box face.
// Reset clears the box bounds to zero and empties the pipeline; no clearing pass.
// Each stage holds its request only while the next is full, so bubbles close up
// and a stall on m_axis loses nothing.
module segment_box_containment_unit
	import sbc_pkg::*;
#(
	parameter int MuFracBits = MuFracDef
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [175:0]         s_axis_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z, kinetic_energy
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [87:0]          m_axis_tdata,  // contained_fraction, escaped_energy, counted_energy, zero pad
	output logic [1:0]           m_axis_tuser,  // fully_escaped, zero_length
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CoordW-1:0]    cfg_data
);

	logic [NumFaces-1:0][CoordW-1:0] box_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_valid && cfg_index <= REG_MAX_Z) begin
			box_q[cfg_index] <= cfg_data;
		end
	end

	logic [NumAxes-1:0][CoordW-1:0] start_pt, end_pt;

	for (genvar a = 0; a < NumAxes; a++) begin : g_unpack
		assign start_pt[a] = s_axis_tdata[a*CoordW +: CoordW];
		assign end_pt[a]   = s_axis_tdata[(a+NumAxes)*CoordW +: CoordW];
	end

	logic                                p_valid, p_ready;
	logic [NumFaces-1:0][CoordW-1:0]     p_anum, p_ad;
	side_t                               p_side;

	sbc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.start_pt  (start_pt),
		.end_pt    (end_pt),
		.energy    (s_axis_tdata[2*NumAxes*CoordW +: EnergyW]),
		.box       (box_q),
		.out_valid (p_valid),
		.out_ready (p_ready),
		.anum      (p_anum),
		.ad        (p_ad),
		.side      (p_side)
	);

	logic                                d_valid, d_ready;
	logic [NumFaces-1:0][MuFracBits-1:0] d_quot;
	logic [NumFaces-1:0]                 d_sat;
	side_t                               d_side;

	sbc_divider #(.MuFracBits(MuFracBits)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.in_ready  (p_ready),
		.anum      (p_anum),
		.ad        (p_ad),
		.side_in   (p_side),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.quot      (d_quot),
		.sat       (d_sat),
		.side_out  (d_side)
	);

	logic [FracOutW-1:0] frac;
	logic [EnergyW-1:0]  escaped, counted;
	logic                fully_escaped, zero_length;

	sbc_resolve #(.MuFracBits(MuFracBits)) u_resolve (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (d_valid),
		.in_ready           (d_ready),
		.quot               (d_quot),
		.sat                (d_sat),
		.side               (d_side),
		.out_valid          (m_axis_tvalid),
		.out_ready          (m_axis_tready),
		.contained_fraction (frac),
		.escaped_energy     (escaped),
		.counted_energy     (counted),
		.fully_escaped      (fully_escaped),
		.zero_length        (zero_length)
	);

	assign m_axis_tdata = {7'b0, counted, escaped, frac};
	assign m_axis_tuser = {zero_length, fully_escaped};

endmodule
